// File: hdl/chained_hash_table_top_assert.svh
// Assertion macros for the checker file of the chained hash table.
// Depends on nothing; include by bare file name.
`ifndef CHAINED_HASH_TABLE_TOP_ASSERT_SVH
`define CHAINED_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define CHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chained hash table assertion failed");

// Next-cycle implication, reset-qualified.
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chained hash table assertion failed");

`endif

// File: hdl/cht_pkg.sv
// Shared types and constants for the chained hash table.
// Used by every module of the block; depends on nothing.
package cht_pkg;

  localparam int MAX_BUCKETS  = 256;
  localparam int POOL_ENTRIES = 64;
  localparam int BKT_W  = $clog2(MAX_BUCKETS);
  localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
  localparam int NODE_W = $clog2(POOL_ENTRIES);
  localparam int LINK_W = 7;
  localparam int STEP_W = $clog2(POOL_ENTRIES + 1);
  localparam int KEY_W  = 31;
  localparam logic [LINK_W-1:0] NIL = 7'd127;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_SEARCH = 2'd2,
    FN_PRINT  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] key;
    logic signed [31:0] bucket_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key_out;
    logic             last;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    func_t            op;
    logic             fail;
    logic [BKT_W-1:0] bucket;
    logic [KEY_W-1:0] key;
  } cmd_t;

  function automatic logic node_ok(input logic [LINK_W-1:0] l);
    return l < LINK_W'(POOL_ENTRIES);
  endfunction

endpackage

// File: hdl/cht_front.sv
// Front end: accepts items, rejects bad ones and computes key mod bucket count.
// Depends on cht_pkg.
module cht_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cht_pkg::in_item_t in_item,
  input  logic [8:0]        eff_cnt,
  output logic              push,
  output cht_pkg::cmd_t     push_cmd,
  input  logic              q_full
);
  import cht_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t          st_r;
  cmd_t             cmd_r;
  logic [BKT_W-1:0] rem_r;
  logic [4:0]       cnt_r;
  logic [BKT_W:0]   trial;
  logic             bad_print;

  assign in_stall = (st_r != F_IDLE);
  assign push     = (st_r == F_PUSH) && !q_full;
  assign push_cmd = cmd_r;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, cmd_r.key[cnt_r]};
  assign bad_print = (eff_cnt == '0) || in_item.bucket_index[31] ||
                     (32'(in_item.bucket_index) >= 32'(eff_cnt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (in_valid) begin
            cmd_r.op <= func_t'(in_item.func);
            cmd_r.key <= in_item.key[KEY_W-1:0];
            rem_r <= '0;
            cnt_r <= 5'(KEY_W - 1);
            if (func_t'(in_item.func) == FN_PRINT) begin
              cmd_r.fail <= bad_print;
              cmd_r.bucket <= in_item.bucket_index[BKT_W-1:0];
              st_r <= F_PUSH;
            end else if ((eff_cnt == '0) || in_item.key[31]) begin
              cmd_r.fail <= 1'b1;
              cmd_r.bucket <= '0;
              st_r <= F_PUSH;
            end else begin
              cmd_r.fail <= 1'b0;
              st_r <= F_DIV;
            end
          end
        end
        F_DIV: begin
          if (trial >= eff_cnt) begin
            rem_r <= BKT_W'(trial - eff_cnt);
          end else begin
            rem_r <= trial[BKT_W-1:0];
          end
          if (cnt_r == '0) begin
            cmd_r.bucket <= (trial >= eff_cnt) ? BKT_W'(trial - eff_cnt)
                                               : trial[BKT_W-1:0];
            st_r <= F_PUSH;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            st_r <= F_IDLE;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/cht_queue.sv
// Two-entry command queue between front and back ends.
// Depends on cht_pkg.
module cht_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cht_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          q_valid,
  output cht_pkg::cmd_t q_cmd,
  input  logic          pop
);
  import cht_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: hdl/cht_back.sv
// Back end: walks chains in the head and node memories and emits results.
// Depends on cht_pkg.
module cht_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cht_pkg::cmd_t      q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output cht_pkg::out_item_t out_item
);
  import cht_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_HEAD, B_WALK, B_PRINT, B_INS, B_TAIL, B_RESP
  } bstate_t;

  bstate_t                st_r;
  cmd_t                   cmd_r;
  logic [LINK_W-1:0]      cur_r, prev_r;
  logic [STEP_W-1:0]      steps_r;
  status_t                status_r;
  logic                   empty_r;
  logic [NODE_W-1:0]      fr_r;
  logic [POOL_ENTRIES-1:0] in_use_r;
  logic [MAX_BUCKETS-1:0] hv_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  // memories
  logic [LINK_W-1:0] heads [MAX_BUCKETS];
  logic [KEY_W-1:0]  nkeys [POOL_ENTRIES];
  logic [LINK_W-1:0] nlinks [POOL_ENTRIES];
  logic [LINK_W-1:0] head_rd_r;
  logic              hv_rd_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [LINK_W-1:0] rd_link_r;

  logic [BKT_W-1:0]  hd_ra;
  logic [NODE_W-1:0] nd_ra;
  logic              hd_we;
  logic [LINK_W-1:0] hd_wdata;
  logic              nk_we, nl_we;
  logic [NODE_W-1:0] n_waddr;
  logic [LINK_W-1:0] n_wlink;

  logic              can_emit;
  logic              emit_now;
  logic [LINK_W-1:0] head_cur;
  logic              key_hit;
  logic              chain_end;
  logic              free_found;
  logic [NODE_W-1:0] free_idx;

  assign can_emit  = !out_valid_r || !out_stall;
  assign emit_now  = can_emit && ((st_r == B_PRINT) || (st_r == B_RESP));
  assign head_cur  = hv_rd_r ? head_rd_r : NIL;
  assign key_hit   = (rd_key_r == cmd_r.key);
  assign chain_end = !node_ok(rd_link_r) ||
                     ((steps_r + STEP_W'(1)) >= STEP_W'(POOL_ENTRIES));
  assign pop       = (st_r == B_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign hd_ra     = (st_r == B_IDLE) ? q_cmd.bucket : cmd_r.bucket;

  // lowest free pool entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = NODE_W'(i);
      end
    end
  end

  // node read address follows the walk
  always_comb begin
    nd_ra = cur_r[NODE_W-1:0];
    unique case (st_r)
      B_HEAD:  nd_ra = head_cur[NODE_W-1:0];
      B_WALK:  if (!key_hit && !chain_end) nd_ra = rd_link_r[NODE_W-1:0];
      B_PRINT: if (can_emit && !chain_end) nd_ra = rd_link_r[NODE_W-1:0];
      default: nd_ra = cur_r[NODE_W-1:0];
    endcase
  end

  // memory write decode
  always_comb begin
    hd_we    = 1'b0;
    hd_wdata = rd_link_r;
    nk_we    = 1'b0;
    nl_we    = 1'b0;
    n_waddr  = prev_r[NODE_W-1:0];
    n_wlink  = rd_link_r;
    unique case (st_r)
      B_WALK: begin
        // delete: unlink the hit node
        if (key_hit && cmd_r.op == FN_DELETE) begin
          if (node_ok(prev_r)) nl_we = 1'b1;
          else                 hd_we = 1'b1;
        end
      end
      B_INS: begin
        if (free_found) begin
          nk_we    = 1'b1;
          nl_we    = 1'b1;
          n_waddr  = free_idx;
          n_wlink  = NIL;
          hd_we    = empty_r;
          hd_wdata = LINK_W'(free_idx);
        end
      end
      B_TAIL: begin
        nl_we   = 1'b1;
        n_waddr = cur_r[NODE_W-1:0];
        n_wlink = LINK_W'(fr_r);
      end
      default: ;
    endcase
  end

  // head memory with valid bits cleared at reset
  always_ff @(posedge clk) begin
    if (hd_we) heads[cmd_r.bucket] <= hd_wdata;
    head_rd_r <= heads[hd_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r    <= '0;
      hv_rd_r <= 1'b0;
    end else begin
      if (hd_we) hv_r[cmd_r.bucket] <= 1'b1;
      hv_rd_r <= hv_r[hd_ra];
    end
  end

  // node pool memories
  always_ff @(posedge clk) begin
    if (nk_we) nkeys[n_waddr] <= cmd_r.key;
    if (nl_we) nlinks[n_waddr] <= n_wlink;
    rd_key_r  <= nkeys[nd_ra];
    rd_link_r <= nlinks[nd_ra];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            status_r <= ST_FAIL;
            st_r <= q_cmd.fail ? B_RESP : B_HEAD;
          end
        end
        B_HEAD: begin
          cur_r   <= head_cur;
          prev_r  <= NIL;
          steps_r <= '0;
          if (cmd_r.op == FN_PRINT) begin
            st_r <= node_ok(head_cur) ? B_PRINT : B_RESP;
          end else if (node_ok(head_cur)) begin
            st_r <= B_WALK;
          end else begin
            empty_r <= 1'b1;
            st_r <= (cmd_r.op == FN_INSERT) ? B_INS : B_RESP;
          end
        end
        B_WALK: begin
          if (key_hit) begin
            status_r <= (cmd_r.op == FN_INSERT) ? ST_FAIL : ST_OK;
            if (cmd_r.op == FN_DELETE) in_use_r[cur_r[NODE_W-1:0]] <= 1'b0;
            st_r <= B_RESP;
          end else if (chain_end) begin
            empty_r <= 1'b0;
            st_r <= (cmd_r.op == FN_INSERT) ? B_INS : B_RESP;
          end else begin
            prev_r  <= cur_r;
            cur_r   <= rd_link_r;
            steps_r <= steps_r + STEP_W'(1);
          end
        end
        B_INS: begin
          if (!free_found) begin
            status_r <= ST_FULL;
            st_r <= B_RESP;
          end else begin
            in_use_r[free_idx] <= 1'b1;
            fr_r <= free_idx;
            status_r <= ST_OK;
            st_r <= empty_r ? B_RESP : B_TAIL;
          end
        end
        B_TAIL: st_r <= B_RESP;
        B_PRINT: begin
          if (can_emit) begin
            out_item_r.status  <= ST_OK;
            out_item_r.key_out <= rd_key_r;
            out_item_r.last    <= chain_end;
            if (chain_end) begin
              st_r <= B_IDLE;
            end else begin
              cur_r   <= rd_link_r;
              steps_r <= steps_r + STEP_W'(1);
            end
          end
        end
        B_RESP: begin
          if (can_emit) begin
            out_item_r.status  <= status_r;
            out_item_r.key_out <= '0;
            out_item_r.last    <= 1'b1;
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/chained_hash_table_top.sv
// Top level of the chained hash table: config register, front, queue, back.
// Depends on cht_pkg, cht_front, cht_queue and cht_back.
//
// Hash set of 31-bit keys with separate chaining over a 64-node pool. Insert,
// delete and search pass the front through accept, one-bit restoring modulo
// over all 31 key bits and push; rejected items and prints skip the modulo.
// In the back, search and delete read the head, walk one step per chain node
// and respond; an append adds insert and tail-link states, an empty-bucket
// insert just the insert state, and print lists one key per step. Results sit
// in the output register; the back overlaps the next item's modulo via a
// two-entry queue. Sustained rate is set by modulo or chain walk, whichever
// is longer, one node read per cycle unless the output stalls. The user must
// write bucket_count via cfg_we only while the block is idle; not enforced.
module chained_hash_table_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cht_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cht_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata
);
  import cht_pkg::*;

  logic [CNT_W-1:0] bucket_count_r;
  logic [CNT_W-1:0] eff_cnt;
  logic             push, q_full, q_valid, pop;
  cmd_t             push_cmd, q_cmd;

  // bucket count register; its effective value is saturated to the table size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= CNT_RESET;
    end else if (cfg_we) begin
      bucket_count_r <= cfg_wdata;
    end
  end

  assign eff_cnt = (bucket_count_r > CNT_W'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS)
                                                          : bucket_count_r;

  cht_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .eff_cnt, .push, .push_cmd, .q_full
  );

  cht_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .full(q_full), .q_valid, .q_cmd, .pop
  );

  cht_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .pop, .out_valid, .out_stall, .out_item
  );
endmodule

// File: hdl/cht_checker.sv
// Port-level checks on the chained hash table results, bound to the top.
// Depends on cht_pkg and chained_hash_table_top_assert.svh.
`include "chained_hash_table_top_assert.svh"

module cht_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input cht_pkg::out_item_t out_item
);
  import cht_pkg::*;

  // a stalled result holds
  `CHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))

  // failures and pool-full end their item
  `CHT_ASSERT_NOW(a_err_last, clk, rst_n, out_valid && out_item.status != ST_OK, out_item.last)

  // a listed key only comes with success
  `CHT_ASSERT_NOW(a_key_ok, clk, rst_n, out_valid && out_item.key_out != '0, out_item.status == ST_OK)

endmodule

bind chained_hash_table_top cht_checker u_cht_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_item(out_item)
);
